// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define I2CM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("i2cm assertion failed");
// checked on every edge, reset included
`define I2CM_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("i2cm assertion failed");
`else
`define I2CM_ASSERT(name, clk, rst_n, prop)
`define I2CM_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== design/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// types and constants shared by the i2c master bit engine modules
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  localparam logic [9:0]  TicksPerUsReset = 10'd100;
  localparam logic [15:0] AckTimeoutReset = 16'd500;
  localparam logic [7:0]  MsbMask         = 8'h80;

  localparam int unsigned InFifoDepth  = 2;
  localparam int unsigned OutFifoDepth = 2;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DelayW   = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TICKS_PER_US = 2'd0,
    CFG_ACK_TIMEOUT  = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_WRITE   = 3'd3,
    OP_READ    = 3'd4,
    OP_ACK     = 3'd5,
    OP_NACK    = 3'd6,
    OP_WAITACK = 3'd7
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ST1  = 4'd1,
    PH_ST2  = 4'd2,
    PH_SP1  = 4'd3,
    PH_SP2  = 4'd4,
    PH_WA1  = 4'd5,
    PH_WA2  = 4'd6,
    PH_POLL = 4'd7,
    PH_AK1  = 4'd8,
    PH_AK2  = 4'd9,
    PH_WR0  = 4'd10,
    PH_WB1  = 4'd11,
    PH_WB2  = 4'd12,
    PH_WB3  = 4'd13,
    PH_RC1  = 4'd14,
    PH_RC2  = 4'd15
  } phase_e;

  typedef struct packed {
    op_e        op;
    logic       is_cmd;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_missing;
  } result_t;

endpackage

`default_nettype wire

// ===== design/i2c_master_bit_engine_core.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// i2c master bit engine: one tick request drives the scl/sda sequencer by one
// clock tick and returns one result with the bus levels and status
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// tick      in         push / full            op_i, tx_byte_i, sda_in_i
// result    out        pop / empty            scl_out_o, sda_out_o, busy_res_o,
//                                             done_res_o, rx_byte_o, ack_missing_o
// config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one tick request per clock sustained; the sequencer takes one queued tick
// per cycle and its result can be popped once it is registered in the result queue
// the tick queue and the result queue let either side stall on its own;
// the sequencer halts while the tick queue is empty or the result queue is full
// after reset the bus is released and the engine is idle, no warm-up cycles
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine_core #(
  parameter int unsigned InDepth  = i2cm_pkg::InFifoDepth,
  parameter int unsigned OutDepth = i2cm_pkg::OutFifoDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [2:0]                    op_i,
  input  logic [7:0]                    tx_byte_i,
  input  logic                          sda_in_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          scl_out_o,
  output logic                          sda_out_o,
  output logic                          busy_res_o,
  output logic                          done_res_o,
  output logic [7:0]                    rx_byte_o,
  output logic                          ack_missing_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [i2cm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [i2cm_pkg::CfgDataW-1:0] cfg_data_i
);

  import i2cm_pkg::*;

  item_t   item;
  logic    in_empty;
  logic    out_full;
  logic    step;
  result_t step_res;
  result_t head_res;

  assign cfg_ready_o = 1'b1;
  assign step        = !in_empty && !out_full;

  i2cm_front #(
    .Depth(InDepth)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .op_i     (op_i),
    .tx_byte_i(tx_byte_i),
    .sda_in_i (sda_in_i),
    .pop_i    (step),
    .item_o   (item),
    .empty_o  (in_empty)
  );

  i2cm_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (item),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (step_res)
  );

  i2cm_fifo #(
    .Width($bits(result_t)),
    .Depth(OutDepth)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (step),
    .wdata_i(step_res),
    .full_o (out_full),
    .pop_i  (pop),
    .rdata_o(head_res),
    .empty_o(empty)
  );

  assign scl_out_o     = head_res.scl_out;
  assign sda_out_o     = head_res.sda_out;
  assign busy_res_o    = head_res.busy_res;
  assign done_res_o    = head_res.done_res;
  assign rx_byte_o     = head_res.rx_byte;
  assign ack_missing_o = head_res.ack_missing;

endmodule

`default_nettype wire

// ===== design/i2cm_fifo.sv =====
// ----------------------------------------------------------------------------
// i2cm_fifo
// small register queue with count based full and empty
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// takes tick requests, decodes the command and queues them for the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_front #(
  parameter int unsigned Depth = i2cm_pkg::InFifoDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          op_i,
  input  logic [7:0]          tx_byte_i,
  input  logic                sda_in_i,
  input  logic                pop_i,
  output i2cm_pkg::item_t     item_o,
  output logic                empty_o
);

  import i2cm_pkg::*;

  item_t item_in;

  always_comb begin
    item_in.op      = op_e'(op_i);
    item_in.is_cmd  = (op_e'(op_i) != OP_NONE);
    item_in.tx_byte = tx_byte_i;
    item_in.sda_in  = sda_in_i;
  end

  i2cm_fifo #(
    .Width($bits(item_t)),
    .Depth(Depth)
  ) u_in_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(item_in),
    .full_o (full),
    .pop_i  (pop_i),
    .rdata_o(item_o),
    .empty_o(empty_o)
  );

endmodule

`default_nettype wire

// ===== design/i2cm_engine.sv =====
// ----------------------------------------------------------------------------
// i2cm_engine
// bus waveform sequencer, one tick per step, plus the configuration registers
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module i2cm_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  i2cm_pkg::item_t                  item_i,
  input  logic                             cfg_we_i,
  input  logic [i2cm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [i2cm_pkg::CfgDataW-1:0]    cfg_data_i,
  output i2cm_pkg::result_t                result_o
);

  import i2cm_pkg::*;

  logic [9:0]        ticks_per_us_q;
  logic [15:0]       ack_timeout_q;

  phase_e            phase_q, phase_d;
  logic [3:0]        bit_count_q, bit_count_d;
  logic [DelayW-1:0] delay_q, delay_d;
  logic [15:0]       poll_q, poll_d;
  logic [7:0]        shift_q, shift_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic [7:0]        rx_hold_q, rx_hold_d;
  logic              ack_err_q, ack_err_d;
  logic              done;

  logic [9:0]        unit;
  logic [DelayW-1:0] dly1, dly2, dly4;
  logic [3:0]        bc_inc;
  logic [15:0]       poll_base;

  // delay reload values for 1, 2 and 4 units, zero unit counts as one
  assign unit   = (ticks_per_us_q == '0) ? 10'd1 : ticks_per_us_q;
  assign dly1   = {2'b00, unit} - 1'b1;
  assign dly2   = {1'b0, unit, 1'b0} - 1'b1;
  assign dly4   = {unit, 2'b00} - 1'b1;
  assign bc_inc = bit_count_q + 1'b1;
  assign poll_base = (phase_q == PH_WA2) ? '0 : poll_q;

  always_comb begin
    phase_d     = phase_q;
    bit_count_d = bit_count_q;
    delay_d     = delay_q;
    poll_d      = poll_q;
    shift_d     = shift_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    rx_hold_d   = rx_hold_q;
    ack_err_d   = ack_err_q;
    done        = 1'b0;

    if (phase_q == PH_IDLE) begin
      if (item_i.is_cmd) begin
        case (item_i.op)
          OP_START: begin
            scl_d = 1'b1; sda_d = 1'b1; phase_d = PH_ST1; delay_d = dly4;
          end
          OP_STOP: begin
            scl_d = 1'b0; sda_d = 1'b0; phase_d = PH_SP1; delay_d = dly4;
          end
          OP_WRITE: begin
            shift_d = item_i.tx_byte; scl_d = 1'b0; phase_d = PH_WR0; delay_d = dly2;
          end
          OP_READ: begin
            sda_d = 1'b1; shift_d = '0; bit_count_d = '0; scl_d = 1'b0;
            phase_d = PH_RC1; delay_d = dly2;
          end
          OP_ACK: begin
            scl_d = 1'b0; sda_d = 1'b0; phase_d = PH_AK1; delay_d = dly2;
          end
          OP_NACK: begin
            scl_d = 1'b0; sda_d = 1'b1; phase_d = PH_AK1; delay_d = dly2;
          end
          default: begin
            ack_err_d = 1'b0; sda_d = 1'b1; phase_d = PH_WA1; delay_d = dly1;
          end
        endcase
      end
    end else if (delay_q != '0) begin
      delay_d = delay_q - 1'b1;
    end else begin
      case (phase_q)
        PH_ST1: begin
          sda_d = 1'b0; phase_d = PH_ST2; delay_d = dly4;
        end
        PH_ST2: begin
          scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
        end
        PH_SP1: begin
          scl_d = 1'b1; sda_d = 1'b1; phase_d = PH_SP2; delay_d = dly4;
        end
        PH_WA1: begin
          scl_d = 1'b1; phase_d = PH_WA2; delay_d = dly1;
        end
        PH_WA2, PH_POLL: begin
          phase_d = PH_POLL;
          poll_d  = poll_base;
          if (!item_i.sda_in) begin
            scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
          end else if (poll_base >= ack_timeout_q) begin
            // no ack in time: flag it and send a stop
            ack_err_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
            phase_d = PH_SP1; delay_d = dly4;
          end else begin
            poll_d = poll_base + 1'b1;
          end
        end
        PH_AK1: begin
          scl_d = 1'b1; phase_d = PH_AK2; delay_d = dly2;
        end
        PH_AK2: begin
          scl_d = 1'b0; phase_d = PH_IDLE; done = 1'b1;
        end
        PH_WR0, PH_WB3: begin
          bit_count_d = (phase_q == PH_WR0) ? 4'd0 : bc_inc;
          if (phase_q == PH_WB3 && bc_inc[3]) begin
            phase_d = PH_IDLE; done = 1'b1;
          end else begin
            sda_d   = shift_q[7];
            shift_d = {shift_q[6:0], 1'b0};
            phase_d = PH_WB1; delay_d = dly2;
          end
        end
        PH_WB1: begin
          scl_d = 1'b1; phase_d = PH_WB2; delay_d = dly2;
        end
        PH_WB2: begin
          scl_d = 1'b0; phase_d = PH_WB3; delay_d = dly1;
        end
        PH_RC1: begin
          scl_d = 1'b1; shift_d = {shift_q[6:0], item_i.sda_in};
          phase_d = PH_RC2; delay_d = dly1;
        end
        PH_RC2: begin
          bit_count_d = bc_inc;
          if (bc_inc[3]) begin
            rx_hold_d = shift_q; phase_d = PH_IDLE; done = 1'b1;
          end else begin
            scl_d = 1'b0; phase_d = PH_RC1; delay_d = dly2;
          end
        end
        default: begin
          phase_d = PH_IDLE; done = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    result_o.scl_out     = scl_d;
    result_o.sda_out     = sda_d;
    result_o.busy_res    = (phase_d != PH_IDLE);
    result_o.done_res    = done;
    result_o.rx_byte     = rx_hold_d;
    result_o.ack_missing = ack_err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_per_us_q <= TicksPerUsReset;
      ack_timeout_q  <= AckTimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TICKS_PER_US: ticks_per_us_q <= cfg_data_i[9:0];
        CFG_ACK_TIMEOUT:  ack_timeout_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_count_q <= '0;
      delay_q     <= '0;
      poll_q      <= '0;
      shift_q     <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      rx_hold_q   <= '0;
      ack_err_q   <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      bit_count_q <= bit_count_d;
      delay_q     <= delay_d;
      poll_q      <= poll_d;
      shift_q     <= shift_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      rx_hold_q   <= rx_hold_d;
      ack_err_q   <= ack_err_d;
    end
  end

  `I2CM_ASSERT(a_done_not_busy, clk_i, rst_ni, (step_i && done) |-> !result_o.busy_res)
  `I2CM_ASSERT(a_idle_no_delay, clk_i, rst_ni, (phase_q == PH_IDLE) |-> (delay_q == '0))
  `I2CM_ASSERT(a_bit_count_range, clk_i, rst_ni, bit_count_q <= 4'd8)
  `I2CM_ASSERT(a_ack_err_from_poll, clk_i, rst_ni,
    $rose(ack_err_q) |-> (phase_q == PH_SP1) &&
    ($past(phase_q) == PH_POLL || $past(phase_q) == PH_WA2))

endmodule

`default_nettype wire

// ===== sim/i2c_master_bit_engine_core_test.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core_test
// self-checking bench for the i2c master bit engine: every clock tick request
// is run through a local copy of the scl/sda sequencer and each popped result
// is compared field by field, under several tick and timeout settings
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine_core_test;
  import i2cm_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 2'd3;

  typedef struct {
    op_e        op;
    logic [7:0] tx;
    logic       sda;
  } tick_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [2:0]          op_i = OP_NONE;
  logic [7:0]          tx_byte_i = 8'h00;
  logic                sda_in_i = 1'b1;
  logic                empty;
  logic                pop = 1'b0;
  logic                scl_out_o;
  logic                sda_out_o;
  logic                busy_res_o;
  logic                done_res_o;
  logic [7:0]          rx_byte_o;
  logic                ack_missing_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_TICKS_PER_US;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  tick_t   tick_q[$];
  result_t bus_expect_q[$];
  logic    tick_taken = 1'b0;

  int cycles = 0;
  int errors = 0;
  int ticks_seen = 0;
  int reg_writes = 0;
  int timeouts = 0;
  int cmds_started[8];

  // bus sequencer state as predicted
  phase_e      eng_ph;
  logic [11:0] eng_delay;
  logic [15:0] eng_polls;
  logic [7:0]  eng_shift;
  logic [3:0]  eng_bits;
  logic        eng_scl;
  logic        eng_sda;
  logic [7:0]  eng_rx;
  logic        eng_ack_err;
  logic        eng_done;
  logic [9:0]  unit_ticks;
  logic [15:0] poll_limit;

  // what the stimulus side assumes about the settings, for sizing commands
  int gen_unit = 100;
  int gen_limit = 500;
  int gen_ticks = 0;

  i2c_master_bit_engine_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .op_i          (op_i),
    .tx_byte_i     (tx_byte_i),
    .sda_in_i      (sda_in_i),
    .empty         (empty),
    .pop           (pop),
    .scl_out_o     (scl_out_o),
    .sda_out_o     (sda_out_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .rx_byte_o     (rx_byte_o),
    .ack_missing_o (ack_missing_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------- sequencer prediction ----------------

  task automatic reset_engine();
    eng_ph      = PH_IDLE;
    eng_delay   = '0;
    eng_polls   = '0;
    eng_shift   = '0;
    eng_bits    = '0;
    eng_scl     = 1'b1;
    eng_sda     = 1'b1;
    eng_rx      = '0;
    eng_ack_err = 1'b0;
    eng_done    = 1'b0;
    unit_ticks  = TicksPerUsReset;
    poll_limit  = AckTimeoutReset;
  endtask

  function automatic logic [11:0] seg_len(int units);
    int u;
    u = (unit_ticks == 0) ? 1 : int'(unit_ticks);
    return 12'(units * u - 1);
  endfunction

  task automatic enter_seg(phase_e ph, int units);
    eng_ph    = ph;
    eng_delay = seg_len(units);
  endtask

  task automatic end_cmd();
    eng_ph    = PH_IDLE;
    eng_delay = '0;
    eng_done  = 1'b1;
  endtask

  task automatic poll_ack(logic s);
    eng_ph    = PH_POLL;
    eng_delay = '0;
    if (!s) begin
      eng_scl = 1'b0;
      end_cmd();
    end else if (eng_polls >= poll_limit) begin
      // no ack in time: flag it and fall into a stop
      eng_ack_err = 1'b1;
      eng_scl     = 1'b0;
      eng_sda     = 1'b0;
      enter_seg(PH_SP1, 4);
      timeouts++;
    end else begin
      eng_polls = eng_polls + 16'd1;
    end
  endtask

  task automatic shift_out();
    eng_sda   = eng_shift[7];
    eng_shift = eng_shift << 1;
    enter_seg(PH_WB1, 2);
  endtask

  task automatic advance_seg(logic s);
    case (eng_ph)
      PH_ST1: begin
        eng_sda = 1'b0;
        enter_seg(PH_ST2, 4);
      end
      PH_ST2: begin
        eng_scl = 1'b0;
        end_cmd();
      end
      PH_SP1: begin
        eng_scl = 1'b1;
        eng_sda = 1'b1;
        enter_seg(PH_SP2, 4);
      end
      PH_SP2: end_cmd();
      PH_WA1: begin
        eng_scl = 1'b1;
        enter_seg(PH_WA2, 1);
      end
      PH_WA2: begin
        eng_polls = '0;
        poll_ack(s);
      end
      PH_POLL: poll_ack(s);
      PH_AK1: begin
        eng_scl = 1'b1;
        enter_seg(PH_AK2, 2);
      end
      PH_AK2: begin
        eng_scl = 1'b0;
        end_cmd();
      end
      PH_WR0: begin
        eng_bits = '0;
        shift_out();
      end
      PH_WB1: begin
        eng_scl = 1'b1;
        enter_seg(PH_WB2, 2);
      end
      PH_WB2: begin
        eng_scl = 1'b0;
        enter_seg(PH_WB3, 1);
      end
      PH_WB3: begin
        eng_bits = eng_bits + 4'd1;
        if (eng_bits >= 4'd8) end_cmd();
        else shift_out();
      end
      PH_RC1: begin
        // sample on the first tick with scl high, msb first
        eng_scl   = 1'b1;
        eng_shift = {eng_shift[6:0], s};
        enter_seg(PH_RC2, 1);
      end
      PH_RC2: begin
        eng_bits = eng_bits + 4'd1;
        if (eng_bits >= 4'd8) begin
          eng_rx = eng_shift;
          end_cmd();
        end else begin
          eng_scl = 1'b0;
          enter_seg(PH_RC1, 2);
        end
      end
      default: end_cmd();
    endcase
  endtask

  task automatic take_cmd(op_e op, logic [7:0] tx);
    cmds_started[int'(op)]++;
    case (op)
      OP_START: begin
        eng_scl = 1'b1;
        eng_sda = 1'b1;
        enter_seg(PH_ST1, 4);
      end
      OP_STOP: begin
        eng_scl = 1'b0;
        eng_sda = 1'b0;
        enter_seg(PH_SP1, 4);
      end
      OP_WRITE: begin
        eng_shift = tx;
        eng_scl   = 1'b0;
        enter_seg(PH_WR0, 2);
      end
      OP_READ: begin
        eng_sda   = 1'b1;
        eng_shift = '0;
        eng_bits  = '0;
        eng_scl   = 1'b0;
        enter_seg(PH_RC1, 2);
      end
      OP_ACK: begin
        eng_scl = 1'b0;
        eng_sda = 1'b0;
        enter_seg(PH_AK1, 2);
      end
      OP_NACK: begin
        eng_scl = 1'b0;
        eng_sda = 1'b1;
        enter_seg(PH_AK1, 2);
      end
      OP_WAITACK: begin
        eng_ack_err = 1'b0;
        eng_sda     = 1'b1;
        enter_seg(PH_WA1, 1);
      end
      default: ;
    endcase
  endtask

  task automatic step_engine(op_e op, logic [7:0] tx, logic s);
    result_t r;
    eng_done = 1'b0;
    if (eng_ph == PH_IDLE) begin
      if (op != OP_NONE) take_cmd(op, tx);
    end else if (eng_delay != 0) begin
      eng_delay = eng_delay - 12'd1;
    end else begin
      advance_seg(s);
    end
    r.scl_out     = eng_scl;
    r.sda_out     = eng_sda;
    r.busy_res    = (eng_ph != PH_IDLE);
    r.done_res    = eng_done;
    r.rx_byte     = eng_rx;
    r.ack_missing = eng_ack_err;
    bus_expect_q.push_back(r);
  endtask

  task automatic apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    reg_writes++;
    case (idx)
      CFG_TICKS_PER_US: unit_ticks = val[9:0];
      CFG_ACK_TIMEOUT:  poll_limit = val;
      default: ;
    endcase
  endtask

  // ---------------- result checking ----------------

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  task automatic check_result();
    result_t want;
    if (bus_expect_q.size() == 0) begin
      errors++;
      $display("%0t: result popped with no request outstanding, expected none, got scl %b sda %b",
               $time, scl_out_o, sda_out_o);
    end else begin
      want = bus_expect_q.pop_front();
      ticks_seen++;
      check_field("scl_out", 8'(want.scl_out), 8'(scl_out_o));
      check_field("sda_out", 8'(want.sda_out), 8'(sda_out_o));
      check_field("busy_res", 8'(want.busy_res), 8'(busy_res_o));
      check_field("done_res", 8'(want.done_res), 8'(done_res_o));
      check_field("rx_byte", want.rx_byte, rx_byte_o);
      check_field("ack_missing", 8'(want.ack_missing), 8'(ack_missing_o));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      tick_taken <= push && !full;
      if (!empty && pop) check_result();
      if (push && !full) step_engine(op_e'(op_i), tx_byte_i, sda_in_i);
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still outstanding",
               cycles, bus_expect_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- driving ----------------

  // random gaps, except in one recurring quiet window
  function automatic bit take_break();
    if ((cycles % 2000) >= 1500) return 1'b0;
    return $urandom_range(99) < 30;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (tick_taken) void'(tick_q.pop_front());
      if (!push || tick_taken) begin
        if (tick_q.size() != 0 && !take_break()) begin
          push      <= 1'b1;
          op_i      <= tick_q[0].op;
          tx_byte_i <= tick_q[0].tx;
          sda_in_i  <= tick_q[0].sda;
        end else begin
          push <= 1'b0;
        end
      end
      pop <= !take_break();
    end
  end

  // ---------------- stimulus ----------------

  task automatic add_tick(op_e op, logic [7:0] tx, logic s);
    tick_t t;
    t.op  = op;
    t.tx  = tx;
    t.sda = s;
    tick_q.push_back(t);
    gen_ticks++;
  endtask

  // one command plus the ticks it needs; hold is the number of high polls
  // before the slave acks a waitack
  task automatic run_cmd(op_e op, logic [7:0] tx, int hold);
    int   len;
    int   ack_at;
    op_e  fop;
    logic s;
    ack_at = 2 * gen_unit + hold;
    case (op)
      OP_START, OP_STOP: len = 8 * gen_unit + 1;
      OP_WRITE:          len = 42 * gen_unit + 1;
      OP_READ:           len = 24 * gen_unit + 1;
      OP_ACK, OP_NACK:   len = 4 * gen_unit + 1;
      OP_WAITACK:        len = (hold > gen_limit) ? 10 * gen_unit + gen_limit + 1 : ack_at + 1;
      default:           len = 1;
    endcase
    add_tick(op, tx, 1'b1);
    for (int i = 1; i < len; i++) begin
      // ops sent while busy must be dropped
      fop = ($urandom_range(3) == 0) ? op_e'(3'($urandom_range(7))) : OP_NONE;
      s = (op == OP_WAITACK) ? (i < ack_at) : 1'($urandom);
      add_tick(fop, 8'($urandom), s);
    end
    repeat ($urandom_range(2)) add_tick(OP_NONE, 8'($urandom), 1'($urandom));
  endtask

  function automatic int ack_hold();
    return $urandom_range(0, gen_limit + 2);
  endfunction

  // fully random ticks, then enough quiet ticks with sda low to let any
  // command they started run out
  task automatic noise(int n);
    repeat (n) add_tick(op_e'(3'($urandom)), 8'($urandom), 1'($urandom));
    repeat (44 * gen_unit + 10) add_tick(OP_NONE, 8'($urandom), 1'b0);
  endtask

  task automatic random_transfer();
    int   nbytes;
    logic rw;
    rw     = 1'($urandom);
    nbytes = $urandom_range(1, 2);
    run_cmd(OP_START, 8'h00, 0);
    run_cmd(OP_WRITE, {7'($urandom), rw}, 0);
    run_cmd(OP_WAITACK, 8'h00, ack_hold());
    for (int b = 0; b < nbytes; b++) begin
      if (rw) begin
        run_cmd(OP_READ, 8'h00, 0);
        run_cmd((b == nbytes - 1) ? OP_NACK : OP_ACK, 8'h00, 0);
      end else begin
        run_cmd(OP_WRITE, 8'($urandom), 0);
        run_cmd(OP_WAITACK, 8'h00, ack_hold());
      end
    end
    run_cmd(OP_STOP, 8'h00, 0);
  endtask

  task automatic wait_drain();
    while (tick_q.size() != 0 || push || bus_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TICKS_PER_US) gen_unit = (val[9:0] == 0) ? 1 : int'(val[9:0]);
    else if (idx == CFG_ACK_TIMEOUT) gen_limit = int'(val);
  endtask

  initial begin
    int         rand_start;
    int         k;
    logic [9:0] u;

    reset_engine();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings
    run_cmd(OP_WAITACK, 8'h00, 2);
    wait_drain();

    // one tick per unit, every op, byte extremes, ack and timeout
    write_reg(CFG_TICKS_PER_US, 16'd1);
    write_reg(CFG_ACK_TIMEOUT, 16'd4);
    write_reg(CfgIdxSpareLo, 16'hFFFF);
    write_reg(CfgIdxSpareHi, 16'h0000);
    run_cmd(OP_NONE, 8'hFF, 0);
    run_cmd(OP_START, 8'h00, 0);
    run_cmd(OP_WRITE, 8'h00, 0);
    run_cmd(OP_WAITACK, 8'h00, 0);
    run_cmd(OP_WRITE, 8'hFF, 0);
    run_cmd(OP_WAITACK, 8'h00, 9);
    run_cmd(OP_READ, 8'h00, 0);
    run_cmd(OP_ACK, 8'h00, 0);
    run_cmd(OP_READ, 8'h00, 0);
    run_cmd(OP_NACK, 8'h00, 0);
    run_cmd(OP_STOP, 8'h00, 0);
    wait_drain();

    // zero unit counts as one, zero timeout fails on the first high poll
    write_reg(CFG_TICKS_PER_US, 16'd0);
    write_reg(CFG_ACK_TIMEOUT, 16'd0);
    run_cmd(OP_WAITACK, 8'h00, 1);
    run_cmd(OP_WAITACK, 8'h00, 0);
    run_cmd(OP_WRITE, 8'hA5, 0);
    run_cmd(OP_READ, 8'h00, 0);
    run_cmd(OP_ACK, 8'h00, 0);
    wait_drain();

    // unit change in the middle of a start, upper data bits dropped
    write_reg(CFG_TICKS_PER_US, 16'hFC03);
    write_reg(CFG_ACK_TIMEOUT, 16'd3);
    add_tick(OP_START, 8'h00, 1'b1);
    repeat (5) add_tick(OP_NONE, 8'h00, 1'b1);
    wait_drain();
    write_reg(CFG_TICKS_PER_US, 16'd1);
    repeat (30) add_tick(OP_NONE, 8'($urandom), 1'($urandom));
    wait_drain();

    // largest timeout
    write_reg(CFG_TICKS_PER_US, 16'd2);
    write_reg(CFG_ACK_TIMEOUT, 16'hFFFF);
    run_cmd(OP_START, 8'h00, 0);
    run_cmd(OP_WAITACK, 8'h00, 150);
    run_cmd(OP_NACK, 8'h00, 0);
    wait_drain();

    // random transfers, single ops and noise over changing settings
    rand_start = gen_ticks;
    while (gen_ticks - rand_start < 1000) begin
      k = $urandom_range(9);
      case (k)
        0:       u = 10'd0;
        6, 7:    u = 10'd2;
        8:       u = 10'd3;
        9:       u = 10'd4;
        default: u = 10'd1;
      endcase
      write_reg(CFG_TICKS_PER_US, {6'($urandom), u});
      write_reg(CFG_ACK_TIMEOUT, 16'($urandom_range(0, 12)));
      repeat (2) begin
        k = $urandom_range(9);
        if (k < 7) random_transfer();
        else if (k < 9) run_cmd(op_e'(3'($urandom_range(1, 7))), 8'($urandom), ack_hold());
        else noise($urandom_range(8, 20));
      end
      wait_drain();
    end

    wait_drain();
    repeat (20) @(posedge clk_i);
    $display("checked %0d bus ticks over %0d register writes, %0d ack timeouts",
             ticks_seen, reg_writes, timeouts);
    $display("commands run: start %0d stop %0d write %0d read %0d ack %0d nack %0d waitack %0d",
             cmds_started[OP_START], cmds_started[OP_STOP], cmds_started[OP_WRITE],
             cmds_started[OP_READ], cmds_started[OP_ACK], cmds_started[OP_NACK],
             cmds_started[OP_WAITACK]);
    if (errors == 0 && bus_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
